// ===== sv/rgba8_box_downsample_2x2_unit_assert.svh =====
// Assertion macros shared by the downsampler modules.
`ifndef RGBA8_BOX_DOWNSAMPLE_2X2_UNIT_ASSERT_SVH
`define RGBA8_BOX_DOWNSAMPLE_2X2_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RBD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define RBD_ASSERT(lbl, prop, msg)
`define RBD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== sv/rbd_pkg.sv =====
// Types and constants of the 2x2 RGBA8 box downsampler.
package rbd_pkg;

  localparam int unsigned MaxEdge   = 1024;
  localparam int unsigned LineDepth = (MaxEdge + 1) / 2;
  localparam int unsigned SlotW     = $clog2(LineDepth);
  localparam int unsigned PosW      = $clog2(MaxEdge);
  localparam int unsigned SizeInW   = 11;
  localparam int unsigned SizeOutW  = 10;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned PairW     = ChanW + 1;
  localparam int unsigned SumW      = ChanW + 2;
  localparam int unsigned NumChan   = 4;
  localparam int unsigned LineW     = NumChan * PairW;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = SizeInW;

  localparam logic [CfgIdxW-1:0] RegSizeIn  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSizeOut = CfgIdxW'(1);

  localparam logic [SizeInW-1:0]  SizeInReset  = SizeInW'(1024);
  localparam logic [SizeOutW-1:0] SizeOutReset = SizeOutW'(512);

  typedef struct packed {
    logic [ChanW-1:0] chan0;
    logic [ChanW-1:0] chan1;
    logic [ChanW-1:0] chan2;
    logic [ChanW-1:0] chan3;
  } in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_chan0;
    logic [ChanW-1:0] out_chan1;
    logic [ChanW-1:0] out_chan2;
    logic [ChanW-1:0] out_chan3;
    logic             last_of_tile;
  } out_t;

  typedef struct packed {
    logic [SizeInW-1:0]  edge_n;
    logic [PosW-1:0]     last;
    logic [SizeOutW-1:0] size_out;
    logic [SizeOutW-1:0] eff_m1;
  } cfg_t;

  typedef logic [NumChan-1:0][PairW-1:0] line_t;

  typedef struct packed {
    line_t pair;
    logic  x_odd;
    logic  z_odd;
    logic  emit;
    logic  last;
  } stage_t;

endpackage

// ===== sv/rbd_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rbd_cfg.sv =====
// Configuration registers and derived image geometry.
module rbd_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rbd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rbd_pkg::CfgDataW-1:0] cfg_data_i,
  output rbd_pkg::cfg_t                cfg_o,
  output logic                         restart_o
);
  import rbd_pkg::*;

  logic [SizeInW-1:0]  size_in_q;
  logic [SizeOutW-1:0] size_out_q;
  logic [SizeInW-1:0]  edge_n;
  logic [SizeInW-1:0]  half_n;
  logic [SizeOutW-1:0] eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_in_q  <= SizeInReset;
      size_out_q <= SizeOutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSizeIn:  size_in_q  <= cfg_data_i[SizeInW-1:0];
        RegSizeOut: size_out_q <= cfg_data_i[SizeOutW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign restart_o = cfg_we_i && ((cfg_idx_i == RegSizeIn) || (cfg_idx_i == RegSizeOut));

  always_comb begin
    priority if (size_in_q == '0) begin
      edge_n = SizeInW'(1);
    end else if (size_in_q > SizeInW'(MaxEdge)) begin
      edge_n = SizeInW'(MaxEdge);
    end else begin
      edge_n = size_in_q;
    end
    half_n = (edge_n + SizeInW'(1)) >> 1;
    eff    = (SizeInW'(size_out_q) < half_n) ? size_out_q : half_n[SizeOutW-1:0];
  end

  assign cfg_o.edge_n   = edge_n;
  assign cfg_o.last     = PosW'(edge_n - SizeInW'(1));
  assign cfg_o.size_out = size_out_q;
  assign cfg_o.eff_m1   = eff - SizeOutW'(1);

endmodule

// ===== sv/rbd_front.sv =====
// Raster position, held texel, horizontal pair sums and line buffer access.
`include "rgba8_box_downsample_2x2_unit_assert.svh"
module rbd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rbd_pkg::cfg_t              cfg_i,
  input  logic                       restart_i,
  input  logic                       accept_i,
  input  rbd_pkg::in_t               in_data_i,
  output logic                       ram_we_o,
  output logic [rbd_pkg::SlotW-1:0]  ram_addr_o,
  output rbd_pkg::line_t             ram_wdata_o,
  output logic                       ram_re_o,
  output logic                       load_o,
  output rbd_pkg::stage_t            stage_o
);
  import rbd_pkg::*;

  logic [PosW-1:0]                col_q, col_d;
  logic [PosW-1:0]                row_q, row_d;
  logic [NumChan-1:0][ChanW-1:0]  held_q;
  logic [NumChan-1:0][ChanW-1:0]  texel;
  line_t                          pair;
  logic                           hold_case;
  logic                           write_case;
  logic [PosW-2:0]                ox;
  logic [PosW-2:0]                oz;

  assign texel = {in_data_i.chan3, in_data_i.chan2, in_data_i.chan1, in_data_i.chan0};

  always_comb begin
    if (SizeInW'(col_q) + SizeInW'(1) < cfg_i.edge_n) begin
      col_d = col_q + PosW'(1);
      row_d = row_q;
    end else begin
      col_d = '0;
      row_d = (SizeInW'(row_q) + SizeInW'(1) < cfg_i.edge_n) ? row_q + PosW'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else if (restart_i) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
      if (hold_case) begin
        held_q <= texel;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      pair[c] = PairW'(texel[c]) + (col_q[0] ? PairW'(held_q[c]) : PairW'(0));
    end
  end

  assign hold_case  = !col_q[0] && (col_q != cfg_i.last);
  assign write_case = !row_q[0] && (row_q != cfg_i.last);
  assign ox         = col_q[PosW-1:1];
  assign oz         = row_q[PosW-1:1];

  assign ram_addr_o  = SlotW'(col_q >> 1);
  assign ram_wdata_o = pair;
  assign ram_we_o    = accept_i && !hold_case && write_case;
  assign load_o      = accept_i && !hold_case && !write_case;
  assign ram_re_o    = load_o && row_q[0];

  assign stage_o.pair  = pair;
  assign stage_o.x_odd = col_q[0];
  assign stage_o.z_odd = row_q[0];
  assign stage_o.emit  = (SizeOutW'(ox) < cfg_i.size_out) && (SizeOutW'(oz) < cfg_i.size_out);
  assign stage_o.last  = (cfg_i.size_out != '0) && (SizeOutW'(ox) == cfg_i.eff_m1) &&
                         (SizeOutW'(oz) == cfg_i.eff_m1);

  `RBD_ASSERT(a_ram_excl, !(ram_we_o && ram_re_o), "line buffer read and write together")
  `RBD_ASSERT(a_col_range, SizeInW'(col_q) < cfg_i.edge_n, "column beyond edge")
  `RBD_ASSERT(a_row_range, SizeInW'(row_q) < cfg_i.edge_n, "row beyond edge")

endmodule

// ===== sv/rbd_back.sv =====
// Vertical sum, mean and output register.
`include "rgba8_box_downsample_2x2_unit_assert.svh"
module rbd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  rbd_pkg::stage_t stage_i,
  input  rbd_pkg::line_t  ram_rdata_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rbd_pkg::out_t   out_data_o
);
  import rbd_pkg::*;

  stage_t                        s1_q;
  logic                          s1_valid_q;
  logic                          s1_emit;
  logic                          out_valid_q;
  out_t                          out_q, out_d;
  logic                          out_ready;
  logic                          s1_ready;
  logic [NumChan-1:0][ChanW-1:0] mean;

  assign s1_emit   = s1_valid_q && s1_q.emit;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || !s1_q.emit || out_ready;
  assign ready_o   = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && load_i) begin
      s1_q <= stage_i;
    end
  end

  always_comb begin
    logic [SumW-1:0] sum;
    logic [1:0]      shamt;
    shamt = {1'b0, s1_q.x_odd} + {1'b0, s1_q.z_odd};
    for (int c = 0; c < NumChan; c++) begin
      sum     = SumW'(s1_q.pair[c]) + (s1_q.z_odd ? SumW'(ram_rdata_i[c]) : SumW'(0));
      sum     = sum >> shamt;
      mean[c] = sum[ChanW-1:0];
    end
    out_d.out_chan0    = mean[0];
    out_d.out_chan1    = mean[1];
    out_d.out_chan2    = mean[2];
    out_d.out_chan3    = mean[3];
    out_d.last_of_tile = s1_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RBD_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_ready, s1_valid_q && $stable(s1_q), "stage lost")
  `RBD_ASSERT_NEXT(a_s1_move, s1_emit && out_ready, out_valid_q, "result dropped")
  `RBD_ASSERT_NEXT(a_no_extra, out_valid_q && !out_stall_i && !s1_emit, !out_valid_q, "duplicate")

endmodule

// ===== sv/rgba8_box_downsample_2x2_unit.sv =====
// Top level of the streaming 2x2 RGBA8 box downsampler.
//
// Source texels enter on the input channel in raster order, one texel per
// item, for a square image of edge size_in. Mip texels leave in raster
// order, edge min(size_out, ceil(size_in/2)), each channel the truncated
// mean of the texels of its 2x2 block; last_of_tile marks the final one.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. Configuration is a write port: index 0 is size_in, index 1 is
// size_out; either write restarts the image at its first texel.
// Throughput is one input item per cycle while in_stall_o is low.
// The input item completing a block loads the stage register behind the
// line buffer read port; the stage register then loads the output
// register, which offers the result.
// A stalled receiver holds the output register, then the stage register,
// and then stalls the input side; nothing is lost meanwhile.
// Reset sets size_in to 1024 and size_out to 512 and returns to the first
// texel. The line buffer is not cleared; each entry is written by an even
// row before the next row reads it.
module rgba8_box_downsample_2x2_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rbd_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rbd_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [rbd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rbd_pkg::CfgDataW-1:0] cfg_data_i
);
  import rbd_pkg::*;

  cfg_t             cfg;
  logic             restart;
  logic             ready;
  logic             accept;
  logic             ram_we;
  logic             ram_re;
  logic [SlotW-1:0] ram_addr;
  line_t            ram_wdata;
  line_t            ram_rdata;
  logic             load;
  stage_t           stage;

  assign accept     = in_valid_i && ready;
  assign in_stall_o = !ready;

  rbd_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  rbd_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .restart_i   (restart),
    .accept_i    (accept),
    .in_data_i,
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .load_o      (load),
    .stage_o     (stage)
  );

  rbd_ram #(
    .Width (LineW),
    .Depth (LineDepth)
  ) u_line (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  rbd_back u_back (
    .clk_i,
    .rst_ni,
    .load_i      (load),
    .stage_i     (stage),
    .ram_rdata_i (ram_rdata),
    .ready_o     (ready),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

// ===== tb/sv/rgba8_box_downsample_2x2_unit_test.sv =====
// Self-checking testbench for the 2x2 RGBA8 box downsampler: predicted mip texels against the DUT.
module rgba8_box_downsample_2x2_unit_test;
  import rbd_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareB = CfgIdxW'(3);
  localparam int unsigned HoldCycles   = 64;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandomItems  = 380;
  localparam int unsigned LargeItems   = 120;

  class mip_scoreboard;
    bit [SizeInW-1:0]  size_in;
    bit [SizeOutW-1:0] size_out;
    bit [LineW-1:0]    pair_line [LineDepth];
    in_t               held;
    int unsigned       col;
    int unsigned       row;
    out_t              mip_due [$];
    int unsigned       texels;
    int unsigned       mip_texels;
    int unsigned       errors;

    function new();
      size_in  = SizeInReset;
      size_out = SizeOutReset;
      restart();
    endfunction

    function void restart();
      held = '0;
      col  = 0;
      row  = 0;
    endfunction

    function int unsigned pending();
      return mip_due.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegSizeIn: begin
          size_in = data[SizeInW-1:0];
          restart();
        end
        RegSizeOut: begin
          size_out = data[SizeOutW-1:0];
          restart();
        end
        default: ;
      endcase
    endfunction

    function void note_texel(in_t t);
      int unsigned n, x, z, lastp, slot, shift, ox, oz, half, eff;
      int unsigned sum [NumChan];
      bit [ChanW-1:0] cur [NumChan];
      bit [ChanW-1:0] prev [NumChan];
      out_t r;
      texels++;
      n = (size_in == 0) ? 1 : ((size_in > MaxEdge) ? MaxEdge : size_in);
      x = col;
      z = row;
      lastp = n - 1;
      if (x + 1 < n) begin
        col = x + 1;
      end else begin
        col = 0;
        row = (z + 1 < n) ? z + 1 : 0;
      end
      if ((x & 1) == 0 && x != lastp) begin
        held = t;
        return;
      end
      cur  = '{t.chan0, t.chan1, t.chan2, t.chan3};
      prev = '{held.chan0, held.chan1, held.chan2, held.chan3};
      shift = x & 1;
      slot = (x >> 1) % LineDepth;
      for (int c = 0; c < NumChan; c++) begin
        sum[c] = cur[c] + (((x & 1) != 0) ? prev[c] : 0);
      end
      if ((z & 1) == 0 && z != lastp) begin
        for (int c = 0; c < NumChan; c++) begin
          pair_line[slot][c*PairW +: PairW] = PairW'(sum[c]);
        end
        return;
      end
      if ((z & 1) != 0) begin
        for (int c = 0; c < NumChan; c++) begin
          sum[c] += pair_line[slot][c*PairW +: PairW];
        end
        shift++;
      end
      ox = x >> 1;
      oz = z >> 1;
      half = (n + 1) >> 1;
      eff = (size_out < half) ? size_out : half;
      if (ox < size_out && oz < size_out) begin
        r.out_chan0 = ChanW'(sum[0] >> shift);
        r.out_chan1 = ChanW'(sum[1] >> shift);
        r.out_chan2 = ChanW'(sum[2] >> shift);
        r.out_chan3 = ChanW'(sum[3] >> shift);
        r.last_of_tile = (eff > 0 && ox == eff - 1 && oz == eff - 1);
        mip_due = {mip_due, r};
      end
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [ChanW-1:0] got, logic [ChanW-1:0] want);
      if (got !== want)
        report($sformatf("mip texel %0d %s got %h want %h", mip_texels, name, got, want));
    endtask

    task check_mip_texel(out_t got);
      out_t want;
      if (mip_due.size() == 0) begin
        report($sformatf("unexpected mip texel %h", got));
        return;
      end
      want = mip_due.pop_front();
      compare_field("out_chan0", got.out_chan0, want.out_chan0);
      compare_field("out_chan1", got.out_chan1, want.out_chan1);
      compare_field("out_chan2", got.out_chan2, want.out_chan2);
      compare_field("out_chan3", got.out_chan3, want.out_chan3);
      compare_field("last_of_tile", ChanW'(got.last_of_tile), ChanW'(want.last_of_tile));
      mip_texels++;
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  mip_scoreboard mip_sb;
  int unsigned   burst_left;
  int unsigned   settings;
  int unsigned   long_holds;
  bit            hold_req;

  rgba8_box_downsample_2x2_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) mip_sb.write_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) mip_sb.note_texel(in_data_i);
      if (out_valid_o && !out_stall_i) mip_sb.check_mip_texel(out_data_o);
    end
  end

  initial begin : stall_pattern
    int unsigned mode, span, k;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        for (k = 0; k < HoldCycles; k++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
        hold_req = 1'b0;
        long_holds++;
      end else begin
        mode = $urandom_range(0, 15);
        span = (mode == 15) ? $urandom_range(30, HoldCycles) : $urandom_range(8, 60);
        k = 0;
        while (k < span && !hold_req) begin
          if (mode < 6) out_stall_i <= 1'b0;
          else if (mode < 10) out_stall_i <= ($urandom_range(0, 1) == 0);
          else if (mode < 13) out_stall_i <= ($urandom_range(0, 3) == 0);
          else if (mode < 15) out_stall_i <= ($urandom_range(0, 3) != 0);
          else out_stall_i <= 1'b1;
          @(posedge clk_i);
          k++;
        end
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [ChanW-1:0] pick_channel();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ChanW'($urandom_range(0, 255));
  endfunction

  function automatic in_t random_texel();
    in_t t;
    t.chan0 = pick_channel();
    t.chan1 = pick_channel();
    t.chan2 = pick_channel();
    t.chan3 = pick_channel();
    return t;
  endfunction

  task automatic offer(input in_t t, input bit no_gaps);
    int unsigned gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 120);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (mip_sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CfgDataW-1:0] si, input logic [CfgDataW-1:0] so);
    settle();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(RegSizeIn, si);
      write_reg(RegSizeOut, so);
    end else begin
      write_reg(RegSizeOut, so);
      write_reg(RegSizeIn, si);
    end
    settings++;
  endtask

  initial begin : stimulus
    int unsigned n_cfg, n, half, so, items, r, k, random_done;
    mip_sb = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= RegSizeIn;
    cfg_data_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes: the start of the first source row
    repeat (LargeItems) offer(random_texel(), 1'b0);

    configure(0, 1);
    offer('0, 1'b0);
    offer('1, 1'b0);
    offer(in_t'{8'h55, 8'hAA, 8'h01, 8'hFE}, 1'b0);

    configure(1, 0);
    offer('1, 1'b0);
    offer(random_texel(), 1'b0);

    configure(2, 1);
    repeat (4) offer('1, 1'b0);

    configure(3, 2);
    repeat (4) offer(random_texel(), 1'b0);
    settle();
    write_reg(RegSpareA, CfgDataW'($urandom_range(0, 2047)));
    write_reg(RegSpareB, '1);
    repeat (5) offer(random_texel(), 1'b0);

    configure(2, 1023);
    repeat (4) offer(random_texel(), 1'b0);

    // oversized source edge clamps to the maximum
    configure(2047, 3);
    repeat (LargeItems) offer(random_texel(), 1'b0);

    // hold the output while the input keeps coming
    configure(1, 1);
    hold_req = 1'b1;
    repeat (80) offer(random_texel(), 1'b1);

    random_done = 0;
    while (random_done < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 65) n_cfg = $urandom_range(1, 12);
      else if (r < 85) n_cfg = $urandom_range(13, 40);
      else if (r < 92) n_cfg = 0;
      else n_cfg = $urandom_range(1, 3);
      n = (n_cfg == 0) ? 1 : n_cfg;
      half = (n + 1) / 2;
      r = $urandom_range(0, 99);
      if (r < 70) so = half;
      else if (r < 78) so = half - 1;
      else if (r < 86) so = half + 1;
      else if (r < 92) so = 0;
      else so = $urandom_range(0, 1023);
      configure(CfgDataW'(n_cfg), {1'($urandom_range(0, 1)), SizeOutW'(so)});
      if (n <= 12) begin
        items = n * n * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) items += $urandom_range(0, n * n - 1);
      end else begin
        items = n * $urandom_range(2, 4) + $urandom_range(0, n - 1);
      end
      repeat (items) offer(random_texel(), 1'b0);
      random_done += items;
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    k = 0;
    while (mip_sb.pending() != 0 && k < 20000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (8) @(posedge clk_i);
    if (mip_sb.pending() != 0)
      mip_sb.report($sformatf("%0d expected mip texels never arrived", mip_sb.pending()));

    $display("Covered %0d source texels and %0d checked mip texels over %0d size settings.",
             mip_sb.texels, mip_sb.mip_texels, settings);
    $display("Output held off at length %0d times; %0d mismatches.", long_holds, mip_sb.errors);
    if (mip_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
